// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files
// Implication in the same cycle and in the following cycle.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds -> cons holds in the same cycle
`define PRT_ASSERT_IMP(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("pending request tracker: assertion failed");

// ante holds -> cons holds in the next cycle
`define PRT_ASSERT_NXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("pending request tracker: assertion failed");

`endif

// File: sv/prt_pkg.sv
// ---------------------------------------------------------------------------
// prt_pkg
// Types, codes and sizes of the pending request tracker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package prt_pkg;

  // table size and timeouts retired per tick
  localparam int SLOTS      = 8;
  localparam int MAX_OUT    = 8;
  localparam int CNT_W      = $clog2(MAX_OUT + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // item functions
  localparam logic [1:0] FUNC_CMD  = 2'd0;
  localparam logic [1:0] FUNC_RESP = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_ACCEPTED   = 3'd0;
  localparam logic [2:0] KIND_BAD_TARGET = 3'd1;
  localparam logic [2:0] KIND_TABLE_FULL = 3'd2;
  localparam logic [2:0] KIND_MATCHED    = 3'd3;
  localparam logic [2:0] KIND_UNMATCHED  = 3'd4;
  localparam logic [2:0] KIND_TIMEOUT    = 3'd5;
  localparam logic [2:0] KIND_NO_EXPIRY  = 3'd6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_NODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST_NODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_MIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_MAX       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_TIMEOUT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_CODE   = 3'd5;

  // operation carried down the chain
  typedef enum logic [2:0] {
    OP_BAD,
    OP_PLAIN,
    OP_ALLOC,
    OP_MATCH,
    OP_TICK
  } op_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  node_id;
    logic [7:0]  resp_request_id;
    logic [7:0]  resp_target;
    logic [7:0]  cmd_code;
    logic        want_reply;
    logic [7:0]  resp_result;
    logic [7:0]  resp_detail;
    logic [31:0] now_ms;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] req_id;
    logic [7:0] src_node;
    logic [7:0] dst_node;
    logic [7:0] orig_cmd;
    logic [7:0] res_code;
    logic [7:0] det_code;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    logic [7:0]  local_node;
    logic [7:0]  broadcast_node;
    logic [7:0]  node_min;
    logic [7:0]  node_max;
    logic [31:0] reply_timeout_ms;
    logic [7:0]  timeout_code;
  } cfg_t;

  // probe passed from cell to cell; hold_* keeps the latest timeout
  typedef struct packed {
    logic             valid;
    op_t              op;
    logic             hit;
    logic [7:0]       node;
    logic [7:0]       id;
    logic [7:0]       cmd;
    logic [31:0]      tm;
    logic             hold_v;
    logic [7:0]       hold_id;
    logic [7:0]       hold_node;
    logic [7:0]       hold_cmd;
    logic [CNT_W-1:0] cnt;
  } probe_t;

  // timeout pushed out by a cell
  typedef struct packed {
    logic       valid;
    logic [7:0] req_id;
    logic [7:0] node;
    logic [7:0] cmd;
  } tmo_t;

endpackage

// File: sv/prt_cell.sv
// ---------------------------------------------------------------------------
// prt_cell
// One table slot. Acts on the probe passing by and hands it on.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prt_cell import prt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic [31:0] limit_cfg,
  input  probe_t      probe_in,
  output probe_t      probe_out,
  output tmo_t        tmo
);

  logic        busy_r, busy_nxt;
  logic [7:0]  id_r, node_r, cmd_r;
  logic [31:0] start_r, limit_r;
  probe_t      probe_r, probe_nxt;
  logic        take, hit, expired, fire;

  // slot decision for the probe
  always_comb begin
    take    = probe_in.valid && (probe_in.op == OP_ALLOC) && !probe_in.hit && !busy_r;
    hit     = probe_in.valid && (probe_in.op == OP_MATCH) && !probe_in.hit && busy_r &&
              (id_r == probe_in.id) && (node_r == probe_in.node);
    expired = (probe_in.tm - start_r) >= limit_r;
    fire    = probe_in.valid && (probe_in.op == OP_TICK) && busy_r && expired &&
              (probe_in.cnt < CNT_W'(MAX_OUT));
    probe_nxt = probe_in;
    busy_nxt  = busy_r;
    tmo       = '0;
    if (take) begin
      probe_nxt.hit = 1'b1;
      busy_nxt      = 1'b1;
    end
    if (hit) begin
      probe_nxt.hit = 1'b1;
      probe_nxt.cmd = cmd_r;
      busy_nxt      = 1'b0;
    end
    if (fire) begin
      // the timeout held so far is not the last one: push it out
      tmo.valid           = probe_in.hold_v;
      tmo.req_id          = probe_in.hold_id;
      tmo.node            = probe_in.hold_node;
      tmo.cmd             = probe_in.hold_cmd;
      probe_nxt.hold_v    = 1'b1;
      probe_nxt.hold_id   = id_r;
      probe_nxt.hold_node = node_r;
      probe_nxt.hold_cmd  = cmd_r;
      probe_nxt.cnt       = probe_in.cnt + CNT_W'(1);
      busy_nxt            = 1'b0;
    end
  end

  // control state and probe stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      probe_r.valid <= 1'b0;
    end else if (adv) begin
      busy_r  <= busy_nxt;
      probe_r <= probe_nxt;
    end
  end

  // slot contents, written on allocation
  always_ff @(posedge clk) begin
    if (adv && take) begin
      id_r    <= probe_in.id;
      node_r  <= probe_in.node;
      cmd_r   <= probe_in.cmd;
      start_r <= probe_in.tm;
      limit_r <= limit_cfg;
    end
  end

  assign probe_out = probe_r;

endmodule

// File: sv/prt_ctrl.sv
// ---------------------------------------------------------------------------
// prt_ctrl
// Item intake, id and time keeping, result formatting and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prt_ctrl import prt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data,
  output logic      adv,
  output probe_t    probe_head,
  input  probe_t    probe_tail,
  input  tmo_t      tmo
);

  logic        busy_r;
  logic [7:0]  next_id_r;
  logic [31:0] cur_time_r;
  in_beat_t    item_r;
  probe_t      probe_r, probe_new;
  logic        out_valid_r;
  out_beat_t   out_r, res_fin, res_tmo;
  logic        accept, start, tgt_ok, fin;
  op_t         op_new;
  logic [7:0]  id_inc, id_step;

  // intake: classify the item and build the probe
  always_comb begin
    adv    = !out_valid_r || !out_stall;
    accept = in_valid && !busy_r;
    tgt_ok = (in_data.node_id == cfg.broadcast_node) ||
             ((in_data.node_id >= cfg.node_min) && (in_data.node_id <= cfg.node_max));
    start  = 1'b0;
    op_new = OP_PLAIN;
    case (in_data.func)
      FUNC_CMD: begin
        start = accept;
        if (!tgt_ok) begin
          op_new = OP_BAD;
        end else if (in_data.want_reply && (in_data.node_id != cfg.broadcast_node)) begin
          op_new = OP_ALLOC;
        end else begin
          op_new = OP_PLAIN;
        end
      end
      FUNC_RESP: begin
        start  = accept;
        op_new = OP_MATCH;
      end
      FUNC_TICK: begin
        start  = accept;
        op_new = OP_TICK;
      end
      default: begin
        start  = 1'b0;
        op_new = OP_PLAIN;
      end
    endcase
    probe_new       = '0;
    probe_new.valid = 1'b1;
    probe_new.op    = op_new;
    probe_new.node  = in_data.node_id;
    probe_new.id    = (op_new == OP_ALLOC) ? next_id_r : in_data.resp_request_id;
    probe_new.cmd   = in_data.cmd_code;
    probe_new.tm    = (op_new == OP_TICK) ? in_data.now_ms : cur_time_r;
  end

  // next request id, zero skipped
  always_comb begin
    id_inc  = next_id_r + 8'd1;
    id_step = (id_inc == 8'd0) ? 8'd1 : id_inc;
  end

  // final result once the probe leaves the chain
  always_comb begin
    fin              = probe_tail.valid && adv;
    res_fin          = '0;
    res_fin.last     = 1'b1;
    res_fin.src_node = cfg.local_node;
    res_fin.dst_node = item_r.node_id;
    res_fin.orig_cmd = item_r.cmd_code;
    case (probe_tail.op)
      OP_BAD: begin
        res_fin.kind = KIND_BAD_TARGET;
      end
      OP_PLAIN: begin
        res_fin.kind = KIND_ACCEPTED;
      end
      OP_ALLOC: begin
        res_fin.kind   = probe_tail.hit ? KIND_ACCEPTED : KIND_TABLE_FULL;
        res_fin.req_id = probe_tail.hit ? probe_tail.id : 8'd0;
      end
      OP_MATCH: begin
        res_fin.kind     = probe_tail.hit ? KIND_MATCHED : KIND_UNMATCHED;
        res_fin.req_id   = item_r.resp_request_id;
        res_fin.src_node = item_r.node_id;
        res_fin.dst_node = item_r.resp_target;
        res_fin.orig_cmd = probe_tail.hit ? probe_tail.cmd : 8'd0;
        res_fin.res_code = item_r.resp_result;
        res_fin.det_code = item_r.resp_detail;
      end
      OP_TICK: begin
        if (probe_tail.hold_v) begin
          res_fin.kind     = KIND_TIMEOUT;
          res_fin.req_id   = probe_tail.hold_id;
          res_fin.src_node = probe_tail.hold_node;
          res_fin.dst_node = cfg.local_node;
          res_fin.orig_cmd = probe_tail.hold_cmd;
          res_fin.res_code = cfg.timeout_code;
        end else begin
          res_fin          = '0;
          res_fin.kind     = KIND_NO_EXPIRY;
          res_fin.last     = 1'b1;
        end
      end
      default: begin
        res_fin.kind = KIND_ACCEPTED;
      end
    endcase
    // earlier timeout of a tick, more may follow
    res_tmo          = '0;
    res_tmo.kind     = KIND_TIMEOUT;
    res_tmo.req_id   = tmo.req_id;
    res_tmo.src_node = tmo.node;
    res_tmo.dst_node = cfg.local_node;
    res_tmo.orig_cmd = tmo.cmd;
    res_tmo.res_code = cfg.timeout_code;
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      next_id_r     <= 8'd1;
      cur_time_r    <= 32'd0;
      probe_r.valid <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (adv) begin
        probe_r.valid <= 1'b0;
      end
      if (start) begin
        busy_r  <= 1'b1;
        item_r  <= in_data;
        probe_r <= probe_new;
        if (op_new == OP_TICK) begin
          cur_time_r <= in_data.now_ms;
        end
      end
      if (fin) begin
        busy_r <= 1'b0;
        if ((probe_tail.op == OP_ALLOC) && probe_tail.hit) begin
          next_id_r <= id_step;
        end
      end
      // output register
      if (adv) begin
        if (fin) begin
          out_valid_r <= 1'b1;
          out_r       <= res_fin;
        end else if (tmo.valid) begin
          out_valid_r <= 1'b1;
          out_r       <= res_tmo;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  assign in_stall   = busy_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign probe_head = probe_r;

endmodule

// File: sv/pending_request_tracker.sv
// ---------------------------------------------------------------------------
// pending_request_tracker
// Outstanding request table with reply timeouts, one slot per cell.
//
// Input channel (in_valid/in_stall/in_data): commands, responses and ticks.
// Result channel (out_valid/out_stall/out_data): one beat per command or
// response, one beat per retired slot (at most eight) or a single no-expiry
// beat per tick; the final beat of an item carries last.
// Config port (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready; the
// user must write it while the block is idle; the block does not enforce it.
// Each item walks a probe down the row of SLOTS cells, one cell a cycle while
// the receiver does not stall; after the last cell the final beat goes into
// the output register. in_stall is high from acceptance until then, so a new
// item is not taken before the last one is through. Extra timeout beats of a
// tick delay it only when the receiver holds the previous one.
// A receiver stall freezes the whole row and the output register.
// Reset frees all slots, sets the next id to 1 and the time to 0; it takes
// effect at once, no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pending_request_tracker import prt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg_r;
  logic   adv;
  probe_t chain_p [SLOTS+1];
  tmo_t   cell_tmo [SLOTS];
  tmo_t   tmo_any;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_node       <= 8'd1;
      cfg_r.broadcast_node   <= 8'd255;
      cfg_r.node_min         <= 8'd1;
      cfg_r.node_max         <= 8'd254;
      cfg_r.reply_timeout_ms <= 32'd1000;
      cfg_r.timeout_code     <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LOCAL_NODE:     cfg_r.local_node       <= cfg_data[7:0];
        CFG_BROADCAST_NODE: cfg_r.broadcast_node   <= cfg_data[7:0];
        CFG_NODE_MIN:       cfg_r.node_min         <= cfg_data[7:0];
        CFG_NODE_MAX:       cfg_r.node_max         <= cfg_data[7:0];
        CFG_REPLY_TIMEOUT:  cfg_r.reply_timeout_ms <= cfg_data[31:0];
        CFG_TIMEOUT_CODE:   cfg_r.timeout_code     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // intake and output side
  prt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .adv        (adv),
    .probe_head (chain_p[0]),
    .probe_tail (chain_p[SLOTS]),
    .tmo        (tmo_any)
  );

  // row of slot cells
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    prt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .limit_cfg (cfg_r.reply_timeout_ms),
      .probe_in  (chain_p[g]),
      .probe_out (chain_p[g+1]),
      .tmo       (cell_tmo[g])
    );
  end

  // at most one cell holds the probe, so OR is enough
  always_comb begin
    tmo_any = '0;
    for (int i = 0; i < SLOTS; i++) begin
      tmo_any = tmo_any | cell_tmo[i];
    end
  end

endmodule

// File: sv/prt_checker.sv
// ---------------------------------------------------------------------------
// prt_checker
// Port level checks of the pending request tracker, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module prt_checker import prt_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  // a held result beat does not move
  `PRT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // an item that gives results blocks the next one
  `PRT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall && (in_data.func == FUNC_CMD || in_data.func == FUNC_RESP || in_data.func == FUNC_TICK), in_stall)

  // only timeouts may be followed by more beats of the same item
  `PRT_ASSERT_IMP(a_not_last_is_tmo, clk, rst_n, out_valid && !out_data.last, out_data.kind == KIND_TIMEOUT)

  // timeouts carry a real id and no detail
  `PRT_ASSERT_IMP(a_tmo_fields, clk, rst_n, out_valid && out_data.kind == KIND_TIMEOUT, out_data.det_code == 8'd0 && out_data.req_id != 8'd0)

endmodule

bind pending_request_tracker prt_checker u_prt_checker (.*);

// File: sim/tracker_checker.sv
// ---------------------------------------------------------------------------
// tracker_checker
// Watches the command, result and register channels of the pending request
// tracker. It keeps its own copy of the request table, works out the result
// beats of every accepted input beat, and compares each result beat field by
// field with the oldest one still waiting.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tracker_checker import prt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_beat_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_beat_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending
);

  // register copy
  logic [7:0]  own_node;
  logic [7:0]  bcast_node;
  logic [7:0]  lo_node;
  logic [7:0]  hi_node;
  logic [31:0] limit_ms;
  logic [7:0]  tmo_code;

  // request table copy
  logic        busy     [SLOTS];
  logic [7:0]  slot_id  [SLOTS];
  logic [7:0]  slot_dst [SLOTS];
  logic [7:0]  slot_op  [SLOTS];
  logic [31:0] slot_t0  [SLOTS];
  logic [31:0] slot_lim [SLOTS];
  logic [7:0]  id_next;
  logic [31:0] now_held;

  out_beat_t   awaited_beats[$];
  int          errors = 0;

  assign mismatches = errors;

  // one line per mismatch, and count it
  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic compare(input string what, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report(what, got, want);
  endtask

  task automatic clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      busy[i]     = 1'b0;
      slot_id[i]  = '0;
      slot_dst[i] = '0;
      slot_op[i]  = '0;
      slot_t0[i]  = '0;
      slot_lim[i] = '0;
    end
    own_node   = 8'd1;
    bcast_node = 8'd255;
    lo_node    = 8'd1;
    hi_node    = 8'd254;
    limit_ms   = 32'd1000;
    tmo_code   = 8'd0;
    id_next    = 8'd1;
    now_held   = '0;
    awaited_beats.delete();
  endtask

  // id counter wraps from 255 to 1, never giving out zero
  task automatic take_request_id(output logic [7:0] id);
    id = id_next;
    id_next = (id_next == 8'hFF) ? 8'h01 : id_next + 8'h01;
  endtask

  task automatic predict_results(input in_beat_t it);
    out_beat_t  r;
    logic       ok;
    logic       found;
    logic [7:0] id;
    logic [31:0] age;
    int         slot;
    r = '0;
    case (it.func)
      FUNC_CMD: begin
        ok = (it.node_id == bcast_node) || (it.node_id >= lo_node && it.node_id <= hi_node);
        r.src_node = own_node;
        r.dst_node = it.node_id;
        r.orig_cmd = it.cmd_code;
        r.kind     = ok ? KIND_ACCEPTED : KIND_BAD_TARGET;
        if (ok && it.want_reply && it.node_id != bcast_node) begin
          slot = -1;
          for (int i = SLOTS - 1; i >= 0; i--)
            if (!busy[i]) slot = i;
          if (slot < 0) begin
            r.kind = KIND_TABLE_FULL;
          end else begin
            take_request_id(id);
            busy[slot]     = 1'b1;
            slot_id[slot]  = id;
            slot_dst[slot] = it.node_id;
            slot_op[slot]  = it.cmd_code;
            slot_t0[slot]  = now_held;
            slot_lim[slot] = limit_ms;
            r.req_id       = id;
          end
        end
        r.last = 1'b1;
        awaited_beats.push_back(r);
      end
      FUNC_RESP: begin
        slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
          if (busy[i] && slot_id[i] == it.resp_request_id && slot_dst[i] == it.node_id)
            slot = i;
        r.req_id   = it.resp_request_id;
        r.src_node = it.node_id;
        r.dst_node = it.resp_target;
        r.res_code = it.resp_result;
        r.det_code = it.resp_detail;
        r.last     = 1'b1;
        if (slot >= 0) begin
          r.kind     = KIND_MATCHED;
          r.orig_cmd = slot_op[slot];
          busy[slot] = 1'b0;
        end else begin
          r.kind = KIND_UNMATCHED;
        end
        awaited_beats.push_back(r);
      end
      FUNC_TICK: begin
        // retire expired slots lowest first; last goes on the final beat
        now_held = it.now_ms;
        found = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          age = now_held - slot_t0[i];
          if (busy[i] && age >= slot_lim[i]) begin
            if (found)
              awaited_beats.push_back(r);
            r = '0;
            r.kind     = KIND_TIMEOUT;
            r.req_id   = slot_id[i];
            r.src_node = slot_dst[i];
            r.dst_node = own_node;
            r.orig_cmd = slot_op[i];
            r.res_code = tmo_code;
            busy[i]    = 1'b0;
            found      = 1'b1;
          end
        end
        if (!found) begin
          r = '0;
          r.kind = KIND_NO_EXPIRY;
        end
        r.last = 1'b1;
        awaited_beats.push_back(r);
      end
      default: ;  // unknown function: no beat, no change
    endcase
  endtask

  always @(posedge clk) begin : watch
    out_beat_t want;
    if (!rst_n) begin
      clear_table();
    end else begin
      // result beat against the oldest expectation
      if (out_valid && !out_stall) begin
        if (awaited_beats.size() == 0) begin
          report("beat with nothing expected, kind", 32'(out_data.kind), 32'd0);
        end else begin
          want = awaited_beats.pop_front();
          compare("kind",     32'(out_data.kind),     32'(want.kind));
          compare("req_id",   32'(out_data.req_id),   32'(want.req_id));
          compare("src_node", 32'(out_data.src_node), 32'(want.src_node));
          compare("dst_node", 32'(out_data.dst_node), 32'(want.dst_node));
          compare("orig_cmd", 32'(out_data.orig_cmd), 32'(want.orig_cmd));
          compare("res_code", 32'(out_data.res_code), 32'(want.res_code));
          compare("det_code", 32'(out_data.det_code), 32'(want.det_code));
          compare("last",     32'(out_data.last),     32'(want.last));
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LOCAL_NODE:     own_node   = cfg_data[7:0];
          CFG_BROADCAST_NODE: bcast_node = cfg_data[7:0];
          CFG_NODE_MIN:       lo_node    = cfg_data[7:0];
          CFG_NODE_MAX:       hi_node    = cfg_data[7:0];
          CFG_REPLY_TIMEOUT:  limit_ms   = cfg_data;
          CFG_TIMEOUT_CODE:   tmo_code   = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        predict_results(in_data);
    end
    pending <= awaited_beats.size();
  end

endmodule

// File: sim/tb.sv
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the pending request tracker. A short directed run
// covers the target checks, table full, matching, expiry and the odd cases;
// random phases then mix commands, responses and ticks under several register
// settings, with random idling on both sides, a long receiver hold and a
// burst of zero-timeout requests. The checker does all the comparing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import prt_pkg::*;;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 16;

  // function code the block ignores
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_beat_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int          mismatches;
  int          pending;
  int          idle_cycles = 0;
  logic        quiet = 1'b0;
  logic        hold_req = 1'b0;
  logic [31:0] clock_ms = '0;
  logic [15:0] open_reqs[$];   // {req_id, node} of requests believed open

  pending_request_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tracker_checker tracker_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog: cycles without any beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, one long hold when asked
  initial begin : receiver
    logic held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 10);
      end
    end
  end

  // keep a list of open requests so responses can hit them
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (out_data.kind == KIND_ACCEPTED && out_data.req_id != 8'd0) begin
        open_reqs.push_back({out_data.req_id, out_data.dst_node});
      end else if (out_data.kind == KIND_TIMEOUT || out_data.kind == KIND_MATCHED) begin
        for (int i = open_reqs.size() - 1; i >= 0; i--)
          if (open_reqs[i][15:8] == out_data.req_id) open_reqs.delete(i);
      end
    end
  end

  // beat with random don't-care fields
  function automatic in_beat_t noise_beat();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return in_beat_t'(raw[$bits(in_beat_t)-1:0]);
  endfunction

  function automatic in_beat_t cmd_beat(input logic [7:0] node, input logic want,
                                        input logic [7:0] code);
    in_beat_t it;
    it            = noise_beat();
    it.func       = FUNC_CMD;
    it.node_id    = node;
    it.want_reply = want;
    it.cmd_code   = code;
    return it;
  endfunction

  function automatic in_beat_t resp_beat(input logic [7:0] node, input logic [7:0] id);
    in_beat_t it;
    it                 = noise_beat();
    it.func            = FUNC_RESP;
    it.node_id         = node;
    it.resp_request_id = id;
    return it;
  endfunction

  function automatic in_beat_t tick_beat(input logic [31:0] now);
    in_beat_t it;
    it        = noise_beat();
    it.func   = FUNC_TICK;
    it.now_ms = now;
    clock_ms  = now;
    return it;
  endfunction

  // offer one beat and wait until it is taken; valid stays up afterwards
  task automatic send_item(input in_beat_t it);
    if (!quiet && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // wait for every result, then let the block run dry
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all six registers back to back
  task automatic load_settings(input cfg_t c);
    logic [CFG_IDX_W-1:0]  idx  [6];
    logic [CFG_DATA_W-1:0] vals [6];
    idx[0] = CFG_LOCAL_NODE;     vals[0] = CFG_DATA_W'(c.local_node);
    idx[1] = CFG_BROADCAST_NODE; vals[1] = CFG_DATA_W'(c.broadcast_node);
    idx[2] = CFG_NODE_MIN;       vals[2] = CFG_DATA_W'(c.node_min);
    idx[3] = CFG_NODE_MAX;       vals[3] = CFG_DATA_W'(c.node_max);
    idx[4] = CFG_REPLY_TIMEOUT;  vals[4] = c.reply_timeout_ms;
    idx[5] = CFG_TIMEOUT_CODE;   vals[5] = CFG_DATA_W'(c.timeout_code);
    settle();
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // random commands, responses and ticks; unknown functions do not count
  task automatic random_items(input int count, input cfg_t c);
    in_beat_t    it;
    int          sent;
    int          pick;
    logic [7:0]  node;
    logic [15:0] entry;
    logic [31:0] span;
    sent = 0;
    span = (c.reply_timeout_ms > 32'd1000) ? 32'd1000 : c.reply_timeout_ms;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        it      = noise_beat();
        it.func = FUNC_UNUSED;
      end else if (pick < 45) begin
        case ($urandom_range(9))
          7:       node = c.broadcast_node;
          8, 9:    node = 8'($urandom_range(255));
          default: node = (c.node_min <= c.node_max) ?
                          8'($urandom_range(c.node_max, c.node_min)) : c.broadcast_node;
        endcase
        it = cmd_beat(node, $urandom_range(3) != 0, 8'($urandom_range(255)));
      end else if (pick < 72) begin
        it = noise_beat();
        it.func = FUNC_RESP;
        if (open_reqs.size() > 0 && $urandom_range(3) != 0) begin
          entry = open_reqs[$urandom_range(open_reqs.size() - 1)];
          it.node_id         = entry[7:0];
          it.resp_request_id = entry[15:8];
        end
      end else if ($urandom_range(9) == 0) begin
        it = tick_beat($urandom);
      end else begin
        it = tick_beat(clock_ms + $urandom_range(3 * span));
      end
      send_item(it);
      if (it.func != FUNC_UNUSED) sent++;
    end
  endtask

  initial begin : stimulus
    cfg_t     c;
    in_beat_t it;
    logic [7:0] fill_nodes [8];
    fill_nodes = '{8'd1, 8'd254, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset settings
    send_item(tick_beat(32'd0));                        // nothing to retire
    send_item(cmd_beat(8'd0, 1'b1, 8'h11));             // below node_min
    send_item(cmd_beat(8'd255, 1'b1, 8'h22));           // broadcast, untracked
    send_item(cmd_beat(8'd254, 1'b0, 8'h33));           // no reply wanted
    for (int i = 0; i < 8; i++)                         // fill the table
      send_item(cmd_beat(fill_nodes[i], 1'b1, (i == 0) ? 8'h00 :
                         (i == 1) ? 8'hFF : 8'($urandom_range(255))));
    send_item(cmd_beat(8'd100, 1'b1, 8'h44));           // table full
    send_item(resp_beat(8'd2, 8'd3));                   // matches slot two
    send_item(resp_beat(8'd2, 8'd3));                   // already freed
    send_item(tick_beat(32'd999));                      // one short of expiry
    send_item(tick_beat(32'd1000));                     // remaining slots expire
    it = noise_beat();
    it.func = FUNC_UNUSED;                              // ignored function
    send_item(it);

    // empty target range: only broadcast passes
    c = '{local_node: 8'hFF, broadcast_node: 8'h00, node_min: 8'd200, node_max: 8'd100,
          reply_timeout_ms: 32'd0, timeout_code: 8'hFF};
    load_settings(c);
    send_item(cmd_beat(8'd150, 1'b1, 8'h55));
    send_item(cmd_beat(8'd0, 1'b1, 8'h66));

    // zero limit expires on the next tick, even with no time passing
    c.node_min = 8'd0;
    c.node_max = 8'd255;
    load_settings(c);
    send_item(cmd_beat(8'd255, 1'b1, 8'h77));
    send_item(tick_beat(32'd1000));

    // elapsed time across the 32-bit wrap
    c.reply_timeout_ms = 32'd10;
    load_settings(c);
    send_item(tick_beat(32'hFFFF_FFFA));
    send_item(cmd_beat(8'd9, 1'b1, 8'h88));
    send_item(tick_beat(32'd3));
    send_item(tick_beat(32'd4));

    // burst of tracked commands with a zero timeout, full table retired per tick
    c = '{local_node: 8'd1, broadcast_node: 8'd255, node_min: 8'd1, node_max: 8'd254,
          reply_timeout_ms: 32'd0, timeout_code: 8'd0};
    load_settings(c);
    for (int k = 0; k < 24; k++) begin
      send_item(cmd_beat(8'($urandom_range(254, 1)), 1'b1, 8'($urandom_range(255))));
      if (k % 8 == 7) send_item(tick_beat($urandom));
    end

    // random phase with the long receiver hold
    c = '{local_node: 8'($urandom_range(255)), broadcast_node: 8'd255, node_min: 8'd1,
          node_max: 8'd254, reply_timeout_ms: $urandom_range(60, 1),
          timeout_code: 8'($urandom_range(255))};
    load_settings(c);
    hold_req <= 1'b1;
    random_items(40, c);

    // widest range, longest timeout, no idling on either side
    c = '{local_node: 8'd0, broadcast_node: 8'd0, node_min: 8'd0, node_max: 8'd255,
          reply_timeout_ms: 32'hFFFF_FFFF, timeout_code: 8'hFF};
    load_settings(c);
    quiet <= 1'b1;
    random_items(40, c);

    // narrow range with broadcast inside it, short timeouts
    c = '{local_node: 8'hFF, broadcast_node: 8'd15, node_min: 8'd10, node_max: 8'd20,
          reply_timeout_ms: $urandom_range(5, 0), timeout_code: 8'd0};
    load_settings(c);
    quiet <= 1'b0;
    random_items(30, c);

    // empty range again, random timeout
    c = '{local_node: 8'($urandom_range(255)), broadcast_node: 8'($urandom_range(255)),
          node_min: 8'd200, node_max: 8'd100, reply_timeout_ms: $urandom,
          timeout_code: 8'($urandom_range(255))};
    load_settings(c);
    random_items(20, c);

    settle();
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
